// File: rtl/txcon_pkg.sv
package txcon_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // Register select is byte address bit 2 (one 32-bit register per word).
   localparam logic [0:0] REG_TEXT_ATTRIBUTE = 1'b0;

   localparam logic [7:0]  ATTR_RESET   = 8'h07;
   localparam logic [15:0] RESET_CELL   = 16'h0720;
   localparam logic [7:0]  BLANK_CHAR   = 8'h20;
   localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  character;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_value;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_column;
      logic        scrolled;
   } rsp_type;

   typedef enum logic [1:0] {
      SWEEP_RESET,
      SWEEP_CLEAR,
      SWEEP_SCROLL
   } sweep_type;

   typedef enum logic [1:0] {
      RES_PLAIN,
      RES_SCROLLED,
      RES_CELL
   } result_type;

   typedef struct packed {
      logic       put;
      logic       clear;
      logic       read;
      logic       sweep_step;
      sweep_type  sweep_mode;
      logic       load_result;
      result_type res_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic scroll_needed;
      logic sweep_last;
   } dp_status_type;

endpackage

// File: rtl/txcon_datapath.sv
module txcon_datapath #(
   parameter int COLUMNS = txcon_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = txcon_pkg::ROWS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  txcon_pkg::dp_cmd_type  cmd,
   output txcon_pkg::dp_status_type status,
   input  txcon_pkg::req_type     req_payload,
   input  logic [7:0]             text_attribute,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output txcon_pkg::rsp_type     rsp_payload
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int AW    = $clog2(CELLS);

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic          is_newline, at_last_col, at_last_row, row_step;

   logic [AW-1:0] ctr_ff, ctr_in;
   logic          sweep_last, copy_now;
   logic [AW:0]   copy_sum;

   logic          wr_valid_ff, wr_valid_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic          wr_copy_ff, wr_copy_in;
   logic [15:0]   wr_fill_ff, wr_fill_in;

   logic          put_write;
   logic [AW-1:0] put_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_data_ff;
   logic          idx_in_range;
   logic          range_ff, range_in;

   logic                rsp_valid_ff, rsp_valid_in;
   txcon_pkg::rsp_type  rsp_ff, rsp_in;

   logic [15:0] mem [CELLS];

   // Cursor
   assign is_newline  = (req_payload.character == txcon_pkg::NEWLINE_CHAR);
   assign at_last_col = (col_ff == CW'(COLUMNS - 1));
   assign at_last_row = (row_ff == RW'(ROWS - 1));
   assign row_step    = is_newline || at_last_col;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.clear) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.put) begin
         if (row_step) begin
            col_in = '0;
            // past the last row the screen scrolls and the cursor stays on that row
            row_in = at_last_row ? row_ff : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign put_write = cmd.put && !is_newline;
   assign put_addr  = AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff);

   // Sweep: one cell per step, the write is registered behind the step so a
   // scroll can pick up the cell one row below from the registered read.
   assign sweep_last = (ctr_ff == AW'(CELLS - 1));
   assign copy_sum   = {1'b0, ctr_ff} + (AW + 1)'(COLUMNS);
   assign copy_now   = cmd.sweep_step && (cmd.sweep_mode == txcon_pkg::SWEEP_SCROLL) &&
                       (ctr_ff < AW'(CELLS - COLUMNS));

   always_comb begin
      ctr_in      = ctr_ff;
      wr_valid_in = cmd.sweep_step;
      wr_addr_in  = ctr_ff;
      wr_copy_in  = copy_now;
      wr_fill_in  = (cmd.sweep_mode == txcon_pkg::SWEEP_RESET) ? txcon_pkg::RESET_CELL :
                    {text_attribute, txcon_pkg::BLANK_CHAR};
      if (cmd.sweep_step) begin
         ctr_in = sweep_last ? '0 : ctr_ff + 1'b1;
      end
   end

   // Memory ports
   assign idx_in_range = (32'(req_payload.cell_index) < CELLS);
   assign range_in     = cmd.read ? idx_in_range : range_ff;

   always_comb begin
      if (cmd.read && idx_in_range) begin
         rd_addr = AW'(req_payload.cell_index);
      end else if (copy_now) begin
         rd_addr = copy_sum[AW-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   assign wr_en   = wr_valid_ff || put_write;
   assign wr_addr = wr_valid_ff ? wr_addr_ff : put_addr;
   assign wr_data = wr_valid_ff ? (wr_copy_ff ? rd_data_ff : wr_fill_ff) :
                    {text_attribute, req_payload.character};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_result) begin
         rsp_valid_in         = 1'b1;
         rsp_in.cell_value    = (cmd.res_kind == txcon_pkg::RES_CELL && range_ff) ?
                                rd_data_ff : 16'h0000;
         rsp_in.cursor_row    = 5'(row_in);
         rsp_in.cursor_column = 7'(col_in);
         rsp_in.scrolled      = (cmd.res_kind == txcon_pkg::RES_SCROLLED);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         ctr_ff       <= '0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         ctr_ff       <= ctr_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wr_addr_ff <= wr_addr_in;
      wr_copy_ff <= wr_copy_in;
      wr_fill_ff <= wr_fill_in;
      range_ff   <= range_in;
      rsp_ff     <= rsp_in;
   end

   assign status.out_free      = !rsp_valid_ff || !rsp_stall;
   assign status.scroll_needed = row_step && at_last_row;
   assign status.sweep_last    = sweep_last;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= RW'(ROWS - 1)) else $error("cursor row past last row");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= CW'(COLUMNS - 1)) else $error("cursor column past row end");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(wr_valid_ff && put_write)) else $error("sweep write collides with put");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> status.out_free) else $error("result overwrites pending item");

endmodule

// File: rtl/txcon_ctrl.sv
module txcon_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               command,
   input  txcon_pkg::dp_status_type status,
   output logic                     req_stall,
   output txcon_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_INIT,
      S_INIT_DRAIN,
      S_IDLE,
      S_SWEEP,
      S_SWEEP_DRAIN,
      S_READ
   } state_type;

   state_type              state_ff, state_in;
   txcon_pkg::sweep_type   mode_ff, mode_in;
   txcon_pkg::result_type  kind_ff, kind_in;
   logic                   idle_ok, accept;

   assign idle_ok   = (state_ff == S_IDLE) && status.out_free;
   assign req_stall = !idle_ok;
   assign accept    = idle_ok && req_valid;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.sweep_mode = mode_ff;
      cmd.res_kind   = txcon_pkg::RES_PLAIN;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep_step = 1'b1;
            cmd.sweep_mode = txcon_pkg::SWEEP_RESET;
            if (status.sweep_last) begin
               state_in = S_INIT_DRAIN;
            end
         end
         S_INIT_DRAIN: begin
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (command)
                  txcon_pkg::CMD_PUT: begin
                     cmd.put = 1'b1;
                     if (status.scroll_needed) begin
                        mode_in  = txcon_pkg::SWEEP_SCROLL;
                        kind_in  = txcon_pkg::RES_SCROLLED;
                        state_in = S_SWEEP;
                     end else begin
                        cmd.load_result = 1'b1;
                     end
                  end
                  txcon_pkg::CMD_CLEAR: begin
                     cmd.clear = 1'b1;
                     mode_in   = txcon_pkg::SWEEP_CLEAR;
                     kind_in   = txcon_pkg::RES_PLAIN;
                     state_in  = S_SWEEP;
                  end
                  txcon_pkg::CMD_READ: begin
                     cmd.read = 1'b1;
                     state_in = S_READ;
                  end
                  default: begin
                     cmd.load_result = 1'b1;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = S_SWEEP_DRAIN;
            end
         end
         S_SWEEP_DRAIN: begin
            cmd.load_result = 1'b1;
            cmd.res_kind    = kind_ff;
            state_in        = S_IDLE;
         end
         S_READ: begin
            cmd.load_result = 1'b1;
            cmd.res_kind    = txcon_pkg::RES_CELL;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         mode_ff  <= txcon_pkg::SWEEP_RESET;
         kind_ff  <= txcon_pkg::RES_PLAIN;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// File: rtl/text_console_writer_unit.sv
// Text console: a COLUMNS x ROWS store of 16-bit cells (attribute in the high
// byte, character in the low byte) with a cursor. After reset the block runs a
// clearing pass that writes 0x0720 to every cell, one cell a cycle, and stays
// stalled until the pass is done. A put of an ordinary character or newline,
// and an unused command code, are answered from the idle state, so a stream
// of puts goes at one item per clock unless stalled. A read goes through a
// read state, as the cell store has a registered read port. A clear, and a
// put that moves the cursor past the last row, sweep the whole store one cell
// a cycle through its single write port (the scroll copies each cell from
// one row below). The text attribute register sits at byte address 0 and
// may only be written while the block is idle.
module text_console_writer_unit #(
   parameter int COLUMNS = txcon_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = txcon_pkg::ROWS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  txcon_pkg::req_type                   req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output txcon_pkg::rsp_type                   rsp_payload,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [txcon_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [txcon_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [txcon_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                 csr_pready
);

   logic [7:0]               attr_ff, attr_in;
   logic                     csr_write;
   txcon_pkg::dp_cmd_type    cmd;
   txcon_pkg::dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign attr_in    = (csr_write && csr_paddr[2] == txcon_pkg::REG_TEXT_ATTRIBUTE) ?
                       csr_pwdata[7:0] : attr_ff;
   assign csr_prdata = (csr_paddr[2] == txcon_pkg::REG_TEXT_ATTRIBUTE) ?
                       txcon_pkg::CSR_DATA_WIDTH'(attr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= txcon_pkg::ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   txcon_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .command   (req_payload.command),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   txcon_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_payload    (req_payload),
      .text_attribute (attr_ff),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload)
   );

endmodule

// File: verif/tb_checker.sv
`timescale 1ns / 1ps

module tb_checker #(
   parameter int COLUMNS = txcon_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = txcon_pkg::ROWS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  txcon_pkg::req_type                   req_payload,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  txcon_pkg::rsp_type                   rsp_payload,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [txcon_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [txcon_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic                                 csr_pready,
   output int                                   mismatch_count,
   output int                                   pending_count
);

   localparam int CELLS = COLUMNS * ROWS;

   logic [15:0]        screen [CELLS];
   int unsigned        row_pos;
   int unsigned        col_pos;
   logic [7:0]         attr;
   txcon_pkg::rsp_type expected_reports [$];
   txcon_pkg::rsp_type oldest;

   function automatic void fill_screen(input logic [15:0] value);
      int i;
      for (i = 0; i < CELLS; i++) screen[i] = value;
   endfunction

   // Updates the console image and cursor for one item, returns its report.
   function automatic txcon_pkg::rsp_type apply_console_command(input txcon_pkg::req_type item);
      txcon_pkg::rsp_type report;
      int unsigned        slot;
      int                 i;
      report = '0;
      case (item.command)
         txcon_pkg::CMD_PUT: begin
            if (item.character == txcon_pkg::NEWLINE_CHAR) begin
               row_pos++;
               col_pos = 0;
            end else begin
               slot = row_pos * COLUMNS + col_pos;
               if (slot < CELLS) screen[slot] = {attr, item.character};
               col_pos++;
               if (col_pos >= COLUMNS) begin
                  col_pos = 0;
                  row_pos++;
               end
            end
            if (row_pos >= ROWS) begin
               for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
               for (i = CELLS - COLUMNS; i < CELLS; i++) begin
                  screen[i] = {attr, txcon_pkg::BLANK_CHAR};
               end
               row_pos = ROWS - 1;
               report.scrolled = 1'b1;
            end
         end
         txcon_pkg::CMD_CLEAR: begin
            fill_screen({attr, txcon_pkg::BLANK_CHAR});
            row_pos = 0;
            col_pos = 0;
         end
         txcon_pkg::CMD_READ: begin
            if (item.cell_index < CELLS) report.cell_value = screen[item.cell_index];
         end
         default: begin
            // unused code: state untouched, cursor reported as is
         end
      endcase
      report.cursor_row    = row_pos[4:0];
      report.cursor_column = col_pos[6:0];
      return report;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fill_screen(txcon_pkg::RESET_CELL);
         row_pos = 0;
         col_pos = 0;
         attr = txcon_pkg::ATTR_RESET;
         expected_reports.delete();
         mismatch_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == txcon_pkg::REG_TEXT_ATTRIBUTE) begin
            attr = csr_pwdata[7:0];
         end
         if (req_valid && !req_stall) begin
            expected_reports.push_back(apply_console_command(req_payload));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected item: cell %h row %0d col %0d scroll %0b",
                           rsp_payload.cell_value, rsp_payload.cursor_row,
                           rsp_payload.cursor_column, rsp_payload.scrolled);
               end
            end else begin
               oldest = expected_reports.pop_front();
               if (rsp_payload.cell_value !== oldest.cell_value ||
                   rsp_payload.cursor_row !== oldest.cursor_row ||
                   rsp_payload.cursor_column !== oldest.cursor_column ||
                   rsp_payload.scrolled !== oldest.scrolled) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: expected cell %h row %0d col %0d scroll %0b",
                              oldest.cell_value, oldest.cursor_row,
                              oldest.cursor_column, oldest.scrolled);
                     $display("          actual   cell %h row %0d col %0d scroll %0b",
                              rsp_payload.cell_value, rsp_payload.cursor_row,
                              rsp_payload.cursor_column, rsp_payload.scrolled);
                  end
               end
            end
         end
      end
      pending_count = expected_reports.size();
   end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int     COLUMNS       = txcon_pkg::COLUMNS_DEFAULT;
   localparam int     ROWS          = txcon_pkg::ROWS_DEFAULT;
   localparam int     CELLS         = COLUMNS * ROWS;
   // a full sweep of the store plus margin
   localparam int     SETTLE_CYCLES = CELLS + 16;
   localparam longint CYCLE_LIMIT   = 64'd8_000_000;
   localparam int     PHASE_ITEMS   = 190;
   localparam int     INDEX_TOP     = 2047;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [txcon_pkg::CSR_ADDR_WIDTH-1:0] ATTR_ADDR =
      {txcon_pkg::REG_TEXT_ATTRIBUTE, 2'b00};

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   txcon_pkg::req_type req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   txcon_pkg::rsp_type rsp_payload;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [txcon_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [txcon_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [txcon_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic               csr_pready;

   int      sender_idle_pct = 0;
   int      receiver_stall_pct = 0;
   int      mismatch_count;
   int      pending_count;
   longint  cycle_count = 0;

   text_console_writer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tb_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic txcon_pkg::req_type console_item(input logic [1:0] command,
                                                       input logic [7:0] character,
                                                       input int index);
      txcon_pkg::req_type item;
      item.command    = command;
      item.character  = character;
      item.cell_index = index[10:0];
      return item;
   endfunction

   function automatic txcon_pkg::req_type random_console_item();
      txcon_pkg::req_type item;
      int                 pick;
      int                 where;
      item = console_item(txcon_pkg::CMD_PUT, 8'($urandom_range(0, 255)),
                          $urandom_range(0, INDEX_TOP));
      pick = $urandom_range(0, 999);
      if (pick < 120) begin
         item.character = txcon_pkg::NEWLINE_CHAR;
      end else if (pick < 123) begin
         item.command = txcon_pkg::CMD_CLEAR;
      end else if (pick < 440) begin
         item.command = txcon_pkg::CMD_READ;
         where = $urandom_range(0, 9);
         // bias reads toward the bottom rows where the cursor usually sits
         if (where < 4) begin
            item.cell_index = 11'((ROWS - 5) * COLUMNS + $urandom_range(0, 5 * COLUMNS - 1));
         end else if (where < 9) begin
            item.cell_index = 11'($urandom_range(0, CELLS - 1));
         end else begin
            item.cell_index = 11'($urandom_range(CELLS, INDEX_TOP));
         end
      end else if (pick < 480) begin
         item.command = CMD_UNUSED;
      end
      return item;
   endfunction

   // Called at a rising edge; returns at the edge where the item was taken.
   task automatic send_item(input txcon_pkg::req_type item);
      logic taken;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic write_text_attribute(input logic [7:0] value);
      logic [txcon_pkg::CSR_DATA_WIDTH-1:0] word;
      logic ready;
      word = $urandom();
      word[7:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ATTR_ADDR;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         ready = csr_pready;
         @(posedge clock);
      end while (!ready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      int left;
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
         left = pending_count;
      end while (left != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int         phase;
      int         n;
      logic [7:0] attr_value;
      int         idle_plan  [5];
      int         stall_plan [5];

      idle_plan  = '{0, 82, 0, 11, 0};
      stall_plan = '{0, 0, 82, 11, 0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, field extremes, every command code
      send_item(console_item(txcon_pkg::CMD_READ, 8'h00, 0));
      send_item(console_item(txcon_pkg::CMD_READ, 8'hFF, INDEX_TOP));
      send_item(console_item(txcon_pkg::CMD_PUT, 8'h00, 0));
      send_item(console_item(txcon_pkg::CMD_PUT, 8'hFF, INDEX_TOP));
      send_item(console_item(txcon_pkg::CMD_PUT, 8'h41, 0));
      send_item(console_item(CMD_UNUSED, 8'hFF, INDEX_TOP));
      send_item(console_item(CMD_UNUSED, 8'h00, 0));
      send_item(console_item(txcon_pkg::CMD_READ, 8'h00, 0));
      send_item(console_item(txcon_pkg::CMD_READ, 8'h00, 1));
      send_item(console_item(txcon_pkg::CMD_READ, 8'h00, 2));
      send_item(console_item(txcon_pkg::CMD_READ, 8'h00, 3));
      send_item(console_item(txcon_pkg::CMD_READ, 8'h00, CELLS - 1));
      send_item(console_item(txcon_pkg::CMD_READ, 8'h00, CELLS));
      send_item(console_item(txcon_pkg::CMD_PUT, txcon_pkg::NEWLINE_CHAR, 0));
      send_item(console_item(txcon_pkg::CMD_PUT, txcon_pkg::BLANK_CHAR, 0));
      send_item(console_item(txcon_pkg::CMD_READ, 8'h00, COLUMNS));
      send_item(console_item(txcon_pkg::CMD_CLEAR, 8'hFF, INDEX_TOP));
      send_item(console_item(txcon_pkg::CMD_READ, 8'h00, 1));
      send_item(console_item(txcon_pkg::CMD_READ, 8'h00, CELLS - 1));
      send_item(console_item(txcon_pkg::CMD_PUT, 8'h55, 0));
      send_item(console_item(txcon_pkg::CMD_READ, 8'h00, 0));

      for (phase = 0; phase < 5; phase++) begin
         wait_drained();
         case (phase)
            0:       attr_value = 8'h00;
            1:       attr_value = 8'hFF;
            4:       attr_value = 8'h1F;
            default: attr_value = 8'($urandom_range(0, 255));
         endcase
         write_text_attribute(attr_value);
         sender_idle_pct    = idle_plan[phase];
         receiver_stall_pct <= stall_plan[phase];
         for (n = 0; n < PHASE_ITEMS; n++) send_item(random_console_item());
      end

      wait_drained();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
